// File: sv/pvmf_pkg.sv
// Shared constants, command and class codes, and request/result types for the
// port VLAN membership filter. No dependencies.
package pvmf_pkg;

    localparam int NUM_PORTS    = 8;   // table rows, 1 to 8
    localparam int MEMBER_SLOTS = 8;   // IDs per list, 1 to 32
    localparam int VID_W        = 12;
    localparam int PORT_W       = 3;
    localparam int MASK_W       = 8;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    // Commands
    localparam logic [3:0] CMD_ADD_TAG   = 4'd0;
    localparam logic [3:0] CMD_ADD_UNTAG = 4'd1;
    localparam logic [3:0] CMD_SET_PVID  = 4'd2;
    localparam logic [3:0] CMD_DEL_TAG   = 4'd3;
    localparam logic [3:0] CMD_DEL_UNTAG = 4'd4;
    localparam logic [3:0] CMD_CLR_PVID  = 4'd5;
    localparam logic [3:0] CMD_CLR_PORT  = 4'd6;
    localparam logic [3:0] CMD_INGRESS   = 4'd7;
    localparam logic [3:0] CMD_EGRESS    = 4'd8;

    // Frame classes
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_TAG   = 2'd1;
    localparam logic [1:0] CLS_UNTAG = 2'd2;
    localparam logic [1:0] CLS_PVID  = 2'd3;

    // Egress edits
    localparam logic [1:0] EDIT_NONE   = 2'd0;
    localparam logic [1:0] EDIT_INSERT = 2'd1;
    localparam logic [1:0] EDIT_REMOVE = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_FILTER_ON = 1'b0;
    localparam logic REG_LAN_MASK  = 1'b1;

    typedef struct packed {
        logic [3:0]        command;
        logic [PORT_W-1:0] port_index;
        logic [PORT_W-1:0] out_port_index;
        logic [VID_W-1:0]  vlan_value;
        logic              frame_tagged;
        logic [1:0]        class_in;
    } t_req;

    typedef struct packed {
        logic             accept;
        logic [1:0]       class_out;
        logic [VID_W-1:0] vlan_out;
        logic [1:0]       edit_action;
    } t_rsp;

    // Lookup of one port row against the request's VLAN ID
    typedef struct packed {
        logic             tag_hit;
        logic             untag_hit;
        logic             has_entries;
        logic [VID_W-1:0] pvid;
    } t_lookup;

    typedef struct packed {
        logic              filter_on;
        logic [MASK_W-1:0] lan_mask;
    } t_cfg;

endpackage

// File: sv/pvmf_table.sv
// Per-port membership table: tagged list, untagged list and pvid per port,
// updated by table commands and looked up for checks. Uses pvmf_pkg.
module pvmf_table import pvmf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_req    i_req,
    output t_lookup o_lookup
);

    typedef logic [MEMBER_SLOTS-1:0][VID_W-1:0] t_list;

    t_list [NUM_PORTS-1:0]            r_tag, n_tag, r_untag, n_untag;
    logic  [NUM_PORTS-1:0][VID_W-1:0] r_pvid, n_pvid;

    logic [PORT_W-1:0] rd_port;
    t_list             rd_tag, rd_untag;
    logic [VID_W-1:0]  rd_pvid;

    function automatic logic list_has(t_list l, logic [VID_W-1:0] id);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < MEMBER_SLOTS; i++) begin
            if (l[i] != '0 && l[i] == id) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic t_list list_add(t_list l, logic [VID_W-1:0] id);
        t_list r;
        logic  done;
        r    = l;
        done = list_has(l, id) || id == '0;
        for (int i = 0; i < MEMBER_SLOTS; i++) begin
            if (!done && l[i] == '0) begin
                r[i] = id;
                done = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_list list_del(t_list l, logic [VID_W-1:0] id);
        t_list r;
        logic  done;
        r    = l;
        done = 1'b0;
        for (int i = 0; i < MEMBER_SLOTS; i++) begin
            if (!done && l[i] != '0 && l[i] == id) begin
                r[i] = '0;
                done = 1'b1;
            end
        end
        return r;
    endfunction

    // Egress looks at the output port, everything else at the input port
    assign rd_port = (i_req.command == CMD_EGRESS) ? i_req.out_port_index : i_req.port_index;

    always_comb begin
        rd_tag   = '0;
        rd_untag = '0;
        rd_pvid  = '0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (int'(rd_port) == p) begin
                rd_tag   = r_tag[p];
                rd_untag = r_untag[p];
                rd_pvid  = r_pvid[p];
            end
        end
    end

    always_comb begin
        o_lookup.tag_hit     = list_has(rd_tag, i_req.vlan_value);
        o_lookup.untag_hit   = list_has(rd_untag, i_req.vlan_value);
        o_lookup.has_entries = (rd_tag != '0) || (rd_untag != '0);
        o_lookup.pvid        = rd_pvid;
    end

    always_comb begin
        n_tag   = r_tag;
        n_untag = r_untag;
        n_pvid  = r_pvid;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (i_wr_en && int'(i_req.port_index) == p) begin
                unique case (i_req.command)
                    CMD_ADD_TAG:   n_tag[p]   = list_add(r_tag[p], i_req.vlan_value);
                    CMD_ADD_UNTAG: n_untag[p] = list_add(r_untag[p], i_req.vlan_value);
                    CMD_SET_PVID:  n_pvid[p]  = i_req.vlan_value;
                    CMD_DEL_TAG:   n_tag[p]   = list_del(r_tag[p], i_req.vlan_value);
                    CMD_DEL_UNTAG: n_untag[p] = list_del(r_untag[p], i_req.vlan_value);
                    CMD_CLR_PVID:  n_pvid[p]  = '0;
                    CMD_CLR_PORT: begin
                        n_tag[p]   = '0;
                        n_untag[p] = '0;
                        n_pvid[p]  = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_untag <= '0;
            r_pvid  <= '0;
        end else begin
            r_tag   <= n_tag;
            r_untag <= n_untag;
            r_pvid  <= n_pvid;
        end
    end

endmodule

// File: sv/pvmf_decide.sv
// Ingress classification and egress filter decision for one request.
// Pure combinational; uses pvmf_pkg and the lookup from pvmf_table.
module pvmf_decide import pvmf_pkg::*; (
    input  t_req    i_req,
    input  t_cfg    i_cfg,
    input  t_lookup i_lookup,
    output t_rsp    o_rsp
);

    logic in_lan, out_lan, pvid_hit;

    function automatic logic is_lan(logic [PORT_W-1:0] p, logic [MASK_W-1:0] mask);
        return (int'(p) < NUM_PORTS) && mask[p];
    endfunction

    assign in_lan   = is_lan(i_req.port_index, i_cfg.lan_mask);
    assign out_lan  = is_lan(i_req.out_port_index, i_cfg.lan_mask);
    assign pvid_hit = (i_lookup.pvid != '0) && (i_lookup.pvid == i_req.vlan_value);

    always_comb begin
        o_rsp.accept      = 1'b1;
        o_rsp.class_out   = CLS_OTHER;
        o_rsp.vlan_out    = '0;
        o_rsp.edit_action = EDIT_NONE;
        if (i_req.command == CMD_INGRESS && i_cfg.filter_on && in_lan) begin
            priority if (i_req.frame_tagged) begin
                if (i_lookup.tag_hit) begin
                    o_rsp.class_out = CLS_TAG;
                    o_rsp.vlan_out  = i_req.vlan_value;
                end else begin
                    o_rsp.accept = 1'b0;
                end
            end else if (i_lookup.pvid != '0) begin
                o_rsp.class_out = CLS_PVID;
                o_rsp.vlan_out  = i_lookup.pvid;
            end else if (i_lookup.has_entries) begin
                o_rsp.accept = 1'b0;
            end else begin
                o_rsp.class_out = CLS_UNTAG;
            end
        end else if (i_req.command == CMD_EGRESS && i_cfg.filter_on && in_lan && out_lan) begin
            if (i_req.class_in != CLS_UNTAG && i_req.vlan_value != '0) begin
                priority if (i_lookup.tag_hit) begin
                    if (!i_req.frame_tagged) o_rsp.edit_action = EDIT_INSERT;
                end else if (i_lookup.untag_hit) begin
                    if (i_req.frame_tagged) o_rsp.edit_action = EDIT_REMOVE;
                end else begin
                    o_rsp.accept = pvid_hit;
                end
            end else if (i_lookup.has_entries || i_lookup.pvid != '0) begin
                o_rsp.accept = 1'b0;
            end
        end
    end

endmodule

// File: sv/port_vlan_membership_filter_top.sv
// Top level of the port VLAN membership filter: APB registers, input
// register, table and decision logic, result register. Uses pvmf_pkg,
// pvmf_table and pvmf_decide.
//
//   channel  direction  handshake                 payload
//   in       request    i_in_valid / o_in_stall   i_in_data  (t_req)
//   out      result     o_out_valid / i_out_stall o_out_data (t_rsp)
//   cfg      APB write  psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each request passes from acceptance through the input register, where the
// table row is looked up and the decision made, then through the result
// register. A new request is accepted every cycle while the result is not stalled.
// Table updates land at the edge the request leaves the input register, so the
// very next request already sees them.
// Reset (synchronous, active low) clears the table, configuration and valid flags at once.
// A stalled result holds the result register; the input register then holds
// too and, if it holds a request, o_in_stall rises.
module port_vlan_membership_filter_top import pvmf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rsp              o_out_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    r_cfg;
    t_req    r_req;
    logic    r_in_valid;
    t_rsp    r_rsp, n_rsp;
    logic    r_out_valid;
    t_lookup lookup;
    logic    out_free, advance, in_accept, cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FILTER_ON: r_cfg.filter_on <= pwdata[0];
                REG_LAN_MASK:  r_cfg.lan_mask  <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FILTER_ON: prdata = {{(APB_DW-1){1'b0}}, r_cfg.filter_on};
            REG_LAN_MASK:  prdata = {{(APB_DW-MASK_W){1'b0}}, r_cfg.lan_mask};
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Move the input register forward whenever the result register is
    // empty or being drained this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_accept || (r_in_valid && !out_free);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    // Hold payloads while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) r_req <= i_in_data;
        if (advance)   r_rsp <= n_rsp;
    end

    // ---------------- table and decision ----------------
    // Write the table only on the edge the request advances, so it lands once.
    pvmf_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (advance),
        .i_req    (r_req),
        .o_lookup (lookup)
    );

    pvmf_decide u_decide (
        .i_req    (r_req),
        .i_cfg    (r_cfg),
        .i_lookup (lookup),
        .o_rsp    (n_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;

`ifndef SYNTH
    // Stall back only when a request is actually parked in the input register
    a_stall_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid) else $error("input stall with empty input register");

    // Table commands always answer accept, class other, no edit
    a_table_cmd_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_req.command <= CMD_CLR_PORT |=>
        o_out_data.accept && o_out_data.class_out == CLS_OTHER &&
        o_out_data.edit_action == EDIT_NONE) else $error("bad table command result");

    // With filtering off, every request is accepted unedited
    a_disabled_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_cfg.filter_on |=>
        o_out_data.accept && o_out_data.edit_action == EDIT_NONE)
        else $error("drop or edit while filtering disabled");

    // Class other never carries a VLAN ID
    a_other_no_vid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.class_out == CLS_OTHER |-> o_out_data.vlan_out == '0)
        else $error("class other with nonzero VLAN ID");

    // An edit comes only with an accepted egress result
    a_edit_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.edit_action != EDIT_NONE |->
        o_out_data.accept && o_out_data.class_out == CLS_OTHER)
        else $error("edit on a dropped or classified result");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the port VLAN membership filter.
// Drives requests and APB register writes and checks every result against a typed
// expectation or an in-file predictor. Depends on pvmf_pkg and port_vlan_membership_filter_top.
module tb;
    import pvmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run length guard and settle time after the last result (two-stage pipe)
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PCT     = 23;
    localparam int REPORT_MAX   = 10;
    // Codes 9 to 15 carry no operation
    localparam logic [3:0] CMD_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_req              i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_rsp              o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    port_vlan_membership_filter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow of the membership table and registers, advanced per accepted request
    logic [VID_W-1:0]  tag_ids   [NUM_PORTS][MEMBER_SLOTS];
    logic [VID_W-1:0]  untag_ids [NUM_PORTS][MEMBER_SLOTS];
    logic [VID_W-1:0]  port_pvid [NUM_PORTS];
    logic              cfg_en;
    logic [MASK_W-1:0] cfg_mask;

    // Results owed by the block, oldest first
    t_rsp pending_rsp[$];

    int  mismatch_cnt;
    int  cycle_cnt;
    bit  quiet_mode;    // both sides stop idling while set
    bit  hold_req;      // ask the receiver for a long hold-off
    int  hold_left;

    // One row of the directed part: a request or a pair of register writes
    typedef struct {
        bit                is_cfg;
        t_req              req;
        bit                has_exp;
        t_rsp              rsp;
        logic              en;
        logic [MASK_W-1:0] mask;
    } stim_row_t;

    stim_row_t stim_rows[$];

    // Clock: 2 ns period
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: end the run if it hangs anywhere
    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_rsp.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit lan_port(input int p);
        return p < NUM_PORTS && p < MASK_W && cfg_mask[p];
    endfunction

    function automatic bit list_hit(input int p, input bit tagged_list,
                                    input logic [VID_W-1:0] vid);
        bit hit;
        hit = 1'b0;
        for (int s = 0; s < MEMBER_SLOTS; s++) begin
            if (tagged_list && tag_ids[p][s] != '0 && tag_ids[p][s] == vid)
                hit = 1'b1;
            if (!tagged_list && untag_ids[p][s] != '0 && untag_ids[p][s] == vid)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic bit port_listed(input int p);
        bit busy;
        busy = 1'b0;
        for (int s = 0; s < MEMBER_SLOTS; s++)
            if (tag_ids[p][s] != '0 || untag_ids[p][s] != '0)
                busy = 1'b1;
        return busy;
    endfunction

    // Compute the filter's answer to one request and apply its table update
    function automatic t_rsp predict_filter(input t_req r);
        t_rsp o;
        int   p;
        int   q;
        int   slot;
        bit   to_tag;
        bit   in_rng;
        o.accept      = 1'b1;
        o.class_out   = CLS_OTHER;
        o.vlan_out    = '0;
        o.edit_action = EDIT_NONE;
        p      = int'(r.port_index);
        q      = int'(r.out_port_index);
        in_rng = p < NUM_PORTS;
        to_tag = (r.command == CMD_ADD_TAG) || (r.command == CMD_DEL_TAG);
        case (r.command)
            CMD_ADD_TAG, CMD_ADD_UNTAG: begin
                // zero, duplicate and full-list adds leave the row alone
                if (in_rng && r.vlan_value != '0 && !list_hit(p, to_tag, r.vlan_value)) begin
                    slot = -1;
                    for (int s = 0; s < MEMBER_SLOTS; s++) begin
                        if (slot < 0 && to_tag && tag_ids[p][s] == '0)
                            slot = s;
                        if (slot < 0 && !to_tag && untag_ids[p][s] == '0)
                            slot = s;
                    end
                    if (slot >= 0 && to_tag)
                        tag_ids[p][slot] = r.vlan_value;
                    else if (slot >= 0)
                        untag_ids[p][slot] = r.vlan_value;
                end
            end
            CMD_DEL_TAG, CMD_DEL_UNTAG: begin
                if (in_rng && r.vlan_value != '0) begin
                    slot = -1;
                    for (int s = 0; s < MEMBER_SLOTS; s++) begin
                        if (slot < 0 && to_tag && tag_ids[p][s] == r.vlan_value)
                            slot = s;
                        if (slot < 0 && !to_tag && untag_ids[p][s] == r.vlan_value)
                            slot = s;
                    end
                    if (slot >= 0 && to_tag)
                        tag_ids[p][slot] = '0;
                    else if (slot >= 0)
                        untag_ids[p][slot] = '0;
                end
            end
            CMD_SET_PVID: begin
                if (in_rng)
                    port_pvid[p] = r.vlan_value;
            end
            CMD_CLR_PVID: begin
                if (in_rng)
                    port_pvid[p] = '0;
            end
            CMD_CLR_PORT: begin
                if (in_rng) begin
                    for (int s = 0; s < MEMBER_SLOTS; s++) begin
                        tag_ids[p][s]   = '0;
                        untag_ids[p][s] = '0;
                    end
                    port_pvid[p] = '0;
                end
            end
            CMD_INGRESS: begin
                if (cfg_en && lan_port(p)) begin
                    if (r.frame_tagged) begin
                        if (list_hit(p, 1'b1, r.vlan_value)) begin
                            o.class_out = CLS_TAG;
                            o.vlan_out  = r.vlan_value;
                        end else begin
                            o.accept = 1'b0;
                        end
                    end else if (port_pvid[p] != '0) begin
                        o.class_out = CLS_PVID;
                        o.vlan_out  = port_pvid[p];
                    end else if (port_listed(p)) begin
                        o.accept = 1'b0;
                    end else begin
                        o.class_out = CLS_UNTAG;
                    end
                end
            end
            CMD_EGRESS: begin
                if (cfg_en && lan_port(p) && lan_port(q)) begin
                    if (r.class_in != CLS_UNTAG && r.vlan_value != '0) begin
                        if (list_hit(q, 1'b1, r.vlan_value)) begin
                            if (!r.frame_tagged)
                                o.edit_action = EDIT_INSERT;
                        end else if (list_hit(q, 1'b0, r.vlan_value)) begin
                            if (r.frame_tagged)
                                o.edit_action = EDIT_REMOVE;
                        end else if (!(port_pvid[q] != '0 && port_pvid[q] == r.vlan_value)) begin
                            o.accept = 1'b0;
                        end
                    end else if (port_listed(q) || port_pvid[q] != '0) begin
                        o.accept = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Offer one request, idling at random first; record its result on acceptance
    task automatic send_req(input t_req r, input bit has_exp, input t_rsp exp_rsp);
        t_rsp pred;
        @(negedge i_clk);
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = r;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_filter(r);
        pending_rsp.push_back(has_exp ? exp_rsp : pred);
    endtask

    // Drop valid and wait until every owed result is back, plus settle time
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready
    task automatic reg_write(input logic idx, input logic [APB_DW-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_FILTER_ON: cfg_en   = val[0];
            REG_LAN_MASK:  cfg_mask = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [MASK_W-1:0] mask);
        wait_drained();
        reg_write(REG_FILTER_ON, APB_DW'(en));
        reg_write(REG_LAN_MASK, APB_DW'(mask));
    endtask

    // Append a directed request; a typed expectation is given where has_exp is set
    task automatic add_row(input logic [3:0] cmd, input int port, input int oport,
                           input int vid, input bit frm_tagged, input logic [1:0] cls,
                           input bit has_exp, input bit acc, input logic [1:0] cls_o,
                           input int vout, input logic [1:0] edit);
        stim_row_t row;
        row.is_cfg                = 1'b0;
        row.req.command           = cmd;
        row.req.port_index        = PORT_W'(port);
        row.req.out_port_index    = PORT_W'(oport);
        row.req.vlan_value        = VID_W'(vid);
        row.req.frame_tagged      = frm_tagged;
        row.req.class_in          = cls;
        row.has_exp               = has_exp;
        row.rsp.accept            = acc;
        row.rsp.class_out         = cls_o;
        row.rsp.vlan_out          = VID_W'(vout);
        row.rsp.edit_action       = edit;
        row.en                    = 1'b0;
        row.mask                  = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg_row(input logic en, input logic [MASK_W-1:0] mask);
        stim_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.en      = en;
        row.mask    = mask;
        stim_rows.push_back(row);
    endtask

    // Mostly IDs from a small pool so lists fill, hit and overflow
    function automatic logic [VID_W-1:0] pick_vid();
        case ($urandom_range(9))
            0: return '0;
            1: return VID_W'($urandom_range(4095));
            2: return '1;
            default: return VID_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 14)      r.command = CMD_ADD_TAG;
        else if (pick < 26) r.command = CMD_ADD_UNTAG;
        else if (pick < 32) r.command = CMD_SET_PVID;
        else if (pick < 40) r.command = CMD_DEL_TAG;
        else if (pick < 46) r.command = CMD_DEL_UNTAG;
        else if (pick < 49) r.command = CMD_CLR_PVID;
        else if (pick < 51) r.command = CMD_CLR_PORT;
        else if (pick < 73) r.command = CMD_INGRESS;
        else if (pick < 96) r.command = CMD_EGRESS;
        else                r.command = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        r.port_index     = PORT_W'($urandom_range(NUM_PORTS - 1));
        r.out_port_index = PORT_W'($urandom_range(NUM_PORTS - 1));
        r.vlan_value     = pick_vid();
        r.frame_tagged   = 1'($urandom_range(1));
        r.class_in       = 2'($urandom_range(3));
        return r;
    endfunction

    // Random requests; with pressure set, also hold off the receiver, run a
    // quiet stretch and pause the sender until the pipe is empty
    task automatic run_random(input int count, input bit pressure);
        t_rsp none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            if (pressure && n == 40)
                hold_req = 1'b1;
            if (pressure)
                quiet_mode = (n >= 150 && n < 300);
            if (pressure && n == 400)
                wait_drained();
            send_req(rand_req(), 1'b0, none);
        end
        quiet_mode = 1'b0;
    endtask

    // Receiver: stall at random or for a long hold-off; check each result taken
    initial begin
        t_rsp exp_rsp;
        t_rsp got;
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pending_rsp.size() == 0) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("unexpected result acc=%0b cls=%0d vid=%0d edit=%0d",
                                 got.accept, got.class_out, got.vlan_out, got.edit_action);
                    mismatch_cnt = mismatch_cnt + 1;
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    if (got.accept !== exp_rsp.accept || got.class_out !== exp_rsp.class_out ||
                        got.vlan_out !== exp_rsp.vlan_out ||
                        got.edit_action !== exp_rsp.edit_action) begin
                        if (mismatch_cnt < REPORT_MAX)
                            $display({"mismatch: exp acc=%0b cls=%0d vid=%0d edit=%0d",
                                      " got acc=%0b cls=%0d vid=%0d edit=%0d"},
                                     exp_rsp.accept, exp_rsp.class_out, exp_rsp.vlan_out,
                                     exp_rsp.edit_action, got.accept, got.class_out,
                                     got.vlan_out, got.edit_action);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                end
            end
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left   = hold_left - 1;
            end else begin
                i_out_stall = !quiet_mode && $urandom_range(99) < IDLE_PCT;
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_en       = 1'b0;
        cfg_mask     = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        quiet_mode   = 1'b0;
        hold_req     = 1'b0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            port_pvid[p] = '0;
            for (int s = 0; s < MEMBER_SLOTS; s++) begin
                tag_ids[p][s]   = '0;
                untag_ids[p][s] = '0;
            end
        end

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. After reset the filter is off: everything passes.
        add_row(CMD_INGRESS, 7, 0, 4095, 1, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_EGRESS, 0, 7, 1, 0, CLS_TAG, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_UNKNOWN_HI, 7, 7, 4095, 1, CLS_PVID, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_cfg_row(1'b1, 8'hFF);
        // Empty port: untagged frames pass as untag, tagged ones drop
        add_row(CMD_INGRESS, 3, 0, 0, 0, CLS_OTHER, 1, 1, CLS_UNTAG, 0, EDIT_NONE);
        add_row(CMD_INGRESS, 3, 0, 5, 1, CLS_OTHER, 1, 0, CLS_OTHER, 0, EDIT_NONE);
        // Zero and duplicate adds change nothing
        add_row(CMD_ADD_TAG, 3, 0, 0, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_ADD_TAG, 3, 0, 4095, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_ADD_TAG, 3, 0, 4095, 1, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_INGRESS, 3, 0, 4095, 1, CLS_OTHER, 1, 1, CLS_TAG, 4095, EDIT_NONE);
        // Listed port without pvid drops untagged frames; once a pvid is set they take it
        add_row(CMD_INGRESS, 3, 0, 0, 0, CLS_OTHER, 1, 0, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_SET_PVID, 3, 0, 1, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_INGRESS, 3, 0, 0, 0, CLS_OTHER, 1, 1, CLS_PVID, 1, EDIT_NONE);
        add_row(CMD_ADD_UNTAG, 3, 0, 100, 1, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        // Egress lookups toward port 3: insert, remove, pvid, miss, untagged class, no ID
        add_row(CMD_EGRESS, 0, 3, 4095, 0, CLS_TAG, 0, 0, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_EGRESS, 0, 3, 100, 1, CLS_TAG, 0, 0, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_EGRESS, 0, 3, 1, 1, CLS_PVID, 0, 0, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_EGRESS, 0, 3, 7, 1, CLS_TAG, 0, 0, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_EGRESS, 0, 3, 4095, 0, CLS_UNTAG, 0, 0, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_EGRESS, 0, 3, 0, 1, CLS_OTHER, 0, 0, CLS_OTHER, 0, EDIT_NONE);
        // Deletes: present, absent, zero; then clear the pvid and a whole port
        add_row(CMD_DEL_TAG, 3, 0, 4095, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_DEL_UNTAG, 3, 0, 55, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_DEL_UNTAG, 3, 0, 0, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_CLR_PVID, 3, 0, 0, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_ADD_TAG, 2, 0, 9, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_CLR_PORT, 2, 0, 0, 0, CLS_OTHER, 1, 1, CLS_OTHER, 0, EDIT_NONE);
        add_row(CMD_INGRESS, 2, 0, 0, 0, CLS_OTHER, 1, 1, CLS_UNTAG, 0, EDIT_NONE);

        foreach (stim_rows[k]) begin
            if (stim_rows[k].is_cfg)
                set_config(stim_rows[k].en, stim_rows[k].mask);
            else
                send_req(stim_rows[k].req, stim_rows[k].has_exp, stim_rows[k].rsp);
        end

        // Random part over several register settings, extremes included
        run_random(600, 1'b1);
        set_config(1'b1, MASK_W'($urandom_range(1, 254)));
        run_random(450, 1'b0);
        set_config(1'b1, 8'h00);
        run_random(150, 1'b0);
        set_config(1'b0, 8'hFF);
        run_random(150, 1'b0);
        set_config(1'b1, 8'hFF);
        run_random(500, 1'b0);

        wait_drained();
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
